// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the waveform decimator checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on clk, quiet while rst is high.
`define WMMD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("wmmd check failed");

// Clocked on clk, also checked while rst is high.
`define WMMD_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("wmmd check failed (reset path)");

`endif

// ----- hdl/wmmd_pkg.sv -----
// ----------------------------------------------------------------------------
// wmmd_pkg
// Constants, types and codes shared by the waveform min/max decimator.
// ----------------------------------------------------------------------------
`default_nettype none

package wmmd_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int MAX_CHANNELS = 8;
  localparam int MAX_COLUMNS  = 8192;
  localparam int MIN_COLUMNS  = 32;
  localparam int MAX_RESULTS  = 64;

  localparam int CHAN_W     = 4;
  localparam int COLS_W     = 14;
  localparam int LEN_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int SUM_W      = SAMPLE_BITS + $clog2(MAX_CHANNELS);
  localparam int CPOS_W     = $clog2(MAX_CHANNELS);
  localparam int COL_IDX_W  = $clog2(MAX_COLUMNS);
  localparam int EMIT_W     = $clog2(MAX_RESULTS + 1);
  localparam int DIV_STEP_W = $clog2(LEN_W + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_LENGTH = CFG_IDX_W'(2);

  // register reset values
  localparam logic [CHAN_W-1:0] CHAN_RESET = CHAN_W'(2);
  localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(800);
  localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(800);

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_CFG_LOAD,
    ST_CFG_DIV,
    ST_IDLE,
    ST_MEAN_LOAD,
    ST_MEAN_DIV,
    ST_COLUMN
  } state_t;

  typedef struct packed {
    logic              start;
    logic [LEN_W-1:0]  dividend;
    logic [COLS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [LEN_W-1:0]  quotient;
    logic [COLS_W-1:0] remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- hdl/wmmd_div.sv -----
// ----------------------------------------------------------------------------
// wmmd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wmmd_div (
  input  wire                 clk,
  input  wire                 rst,
  input  wmmd_pkg::div_req_t  req,
  output wmmd_pkg::div_rsp_t  rsp
);

  logic [wmmd_pkg::LEN_W-1:0]      quo;
  logic [wmmd_pkg::COLS_W-1:0]     rem;
  logic [wmmd_pkg::DIV_STEP_W-1:0] cnt;
  logic                            busy;
  logic                            done;
  logic [wmmd_pkg::COLS_W-1:0]     divisor;

  logic [wmmd_pkg::COLS_W:0]       shifted;
  logic                            ge;
  logic [wmmd_pkg::COLS_W:0]       diff;

  always_comb begin
    shifted = {rem, quo[wmmd_pkg::LEN_W-1]};
    ge      = shifted >= {1'b0, divisor};
    diff    = shifted - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        cnt     <= wmmd_pkg::DIV_STEP_W'(wmmd_pkg::LEN_W);
        quo     <= req.dividend;
        rem     <= '0;
        divisor <= req.divisor;
      end else if (busy) begin
        // partial remainder stays below the divisor, so the low bits suffice
        rem <= ge ? diff[wmmd_pkg::COLS_W-1:0] : shifted[wmmd_pkg::COLS_W-1:0];
        quo <= {quo[wmmd_pkg::LEN_W-2:0], ge};
        cnt <= cnt - wmmd_pkg::DIV_STEP_W'(1);
        if (cnt == wmmd_pkg::DIV_STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

`default_nettype wire

// ----- hdl/waveform_min_max_decimator.sv -----
// ----------------------------------------------------------------------------
// waveform_min_max_decimator
// Min/max peak decimator that builds a waveform overview of one segment.
// ----------------------------------------------------------------------------
// Interleaved channel samples enter one item at a time. Each frame of
// channel_count samples is summed and divided by the channel count
// (truncating toward zero) to give a mono value. The segment_length frames
// are split into column_count columns; column k spans frames
// floor(k*N/W) .. max(floor(k*N/W)+1, floor((k+1)*N/W)) - 1, and each closed
// column is reported as one output item with its min, max, index and a
// last-column flag. With fewer frames than columns one frame closes several
// columns, reported in order, at most 64 per frame. After the final column
// the counters restart for the next segment.
// A sample that does not complete a frame is accepted without a stall.
// A frame-completing sample holds in_stall while the shared 24-step
// serial divider forms the channel mean and while the columns it closes
// are stepped (longer if out_stall holds the output register). Reset and
// any write to a listed register restart the segment and run the same
// divider on segment_length / column_count, with in_stall high until it
// is done. Out-of-range register values are clamped (channels 1..8,
// columns 32..8192, length at least 1); writes to an unlisted index
// are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module waveform_min_max_decimator (
  input  wire                                         clk,
  input  wire                                         rst,
  // configuration write port
  input  wire                                         cfg_write,
  input  wire [wmmd_pkg::CFG_IDX_W-1:0]               cfg_index,
  input  wire [wmmd_pkg::CFG_DATA_W-1:0]              cfg_data,
  // sample input
  input  wire                                         in_valid,
  output logic                                        in_stall,
  input  wire signed [wmmd_pkg::SAMPLE_BITS-1:0]      sample_value,
  // column output
  output logic                                        out_valid,
  input  wire                                         out_stall,
  output logic signed [wmmd_pkg::SAMPLE_BITS-1:0]     column_min,
  output logic signed [wmmd_pkg::SAMPLE_BITS-1:0]     column_max,
  output logic [wmmd_pkg::COL_IDX_W-1:0]              column_index,
  output logic                                        last_column
);

  // configuration registers
  logic [wmmd_pkg::CHAN_W-1:0]  chan_cfg;
  logic [wmmd_pkg::COLS_W-1:0]  cols_cfg;
  logic [wmmd_pkg::LEN_W-1:0]   len_cfg;

  // N / W split, kept for column stepping and segment restart
  logic [wmmd_pkg::LEN_W-1:0]     step_q;
  logic [wmmd_pkg::COL_IDX_W-1:0] step_r;

  // segment state
  wmmd_pkg::state_t                       state, state_next;
  logic signed [wmmd_pkg::SUM_W-1:0]      frame_sum;
  logic [wmmd_pkg::CPOS_W-1:0]            channel_position;
  logic [wmmd_pkg::LEN_W-1:0]             frame_position;
  logic [wmmd_pkg::COL_IDX_W-1:0]         current_column;
  logic [wmmd_pkg::LEN_W-1:0]             column_start;
  logic [wmmd_pkg::LEN_W-1:0]             column_end_frame;
  logic [wmmd_pkg::COL_IDX_W-1:0]         boundary_residue;
  logic signed [wmmd_pkg::SAMPLE_BITS-1:0] running_min;
  logic signed [wmmd_pkg::SAMPLE_BITS-1:0] running_max;
  logic signed [wmmd_pkg::SAMPLE_BITS-1:0] mono;
  logic [wmmd_pkg::EMIT_W-1:0]            emit_cnt;

  wmmd_pkg::div_req_t div_req;
  wmmd_pkg::div_rsp_t div_rsp;

  // effective (clamped) settings
  logic [wmmd_pkg::CHAN_W-1:0] chans_eff;
  logic [wmmd_pkg::COLS_W-1:0] cols_eff;
  logic [wmmd_pkg::LEN_W-1:0]  len_eff;

  always_comb begin
    if (chan_cfg == '0)
      chans_eff = wmmd_pkg::CHAN_W'(1);
    else if (chan_cfg > wmmd_pkg::CHAN_W'(wmmd_pkg::MAX_CHANNELS))
      chans_eff = wmmd_pkg::CHAN_W'(wmmd_pkg::MAX_CHANNELS);
    else
      chans_eff = chan_cfg;

    if (cols_cfg < wmmd_pkg::COLS_W'(wmmd_pkg::MIN_COLUMNS))
      cols_eff = wmmd_pkg::COLS_W'(wmmd_pkg::MIN_COLUMNS);
    else if (cols_cfg > wmmd_pkg::COLS_W'(wmmd_pkg::MAX_COLUMNS))
      cols_eff = wmmd_pkg::COLS_W'(wmmd_pkg::MAX_COLUMNS);
    else
      cols_eff = cols_cfg;

    len_eff = (len_cfg == '0) ? wmmd_pkg::LEN_W'(1) : len_cfg;
  end

  // config write to a listed register restarts the segment
  logic cfg_hit;
  assign cfg_hit = cfg_write && ((cfg_index == wmmd_pkg::REG_CHANNEL_COUNT) ||
                                 (cfg_index == wmmd_pkg::REG_COLUMN_COUNT) ||
                                 (cfg_index == wmmd_pkg::REG_SEGMENT_LENGTH));

  // input side
  logic                              in_acc;
  logic signed [wmmd_pkg::SUM_W-1:0] sum_next;
  logic [wmmd_pkg::CPOS_W:0]         cpos_inc;
  logic                              frame_close;

  assign in_stall    = (state != wmmd_pkg::ST_IDLE);
  assign in_acc      = in_valid && !in_stall;
  assign sum_next    = frame_sum + wmmd_pkg::SUM_W'(sample_value);
  assign cpos_inc    = {1'b0, channel_position} + (wmmd_pkg::CPOS_W+1)'(1);
  assign frame_close = ((wmmd_pkg::CHAN_W)'(cpos_inc) >= chans_eff);

  // channel mean: magnitude through the divider, sign put back afterwards
  logic [wmmd_pkg::SUM_W-1:0]              sum_mag;
  logic [wmmd_pkg::SAMPLE_BITS-1:0]        quot_lo;
  logic signed [wmmd_pkg::SAMPLE_BITS-1:0] mean_val;

  assign sum_mag  = frame_sum[wmmd_pkg::SUM_W-1] ? wmmd_pkg::SUM_W'(-frame_sum)
                                                 : wmmd_pkg::SUM_W'(frame_sum);
  assign quot_lo  = div_rsp.quotient[wmmd_pkg::SAMPLE_BITS-1:0];
  assign mean_val = frame_sum[wmmd_pkg::SUM_W-1] ? -$signed(quot_lo) : $signed(quot_lo);

  always_comb begin
    div_req.start = (state == wmmd_pkg::ST_CFG_LOAD) || (state == wmmd_pkg::ST_MEAN_LOAD);
    if (state == wmmd_pkg::ST_MEAN_LOAD) begin
      div_req.dividend = wmmd_pkg::LEN_W'(sum_mag);
      div_req.divisor  = wmmd_pkg::COLS_W'(chans_eff);
    end else begin
      div_req.dividend = len_eff;
      div_req.divisor  = cols_eff;
    end
  end

  wmmd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // column boundary logic
  logic [wmmd_pkg::LEN_W:0]      start_inc;
  logic [wmmd_pkg::LEN_W:0]      col_stop;
  logic [wmmd_pkg::LEN_W:0]      frame_inc;
  logic                          col_hit;
  logic                          is_last;
  logic                          can_emit;
  logic                          out_free;
  logic                          step_ok;
  logic                          out_load;
  logic [wmmd_pkg::COLS_W-1:0]   res_sum;
  logic                          res_wrap;
  logic [wmmd_pkg::COLS_W-1:0]   res_next;
  logic [wmmd_pkg::LEN_W-1:0]    end_adv;
  logic                          refold;

  always_comb begin
    start_inc = {1'b0, column_start} + (wmmd_pkg::LEN_W+1)'(1);
    col_stop  = ({1'b0, column_end_frame} < start_inc) ? start_inc
                                                        : {1'b0, column_end_frame};
    frame_inc = {1'b0, frame_position} + (wmmd_pkg::LEN_W+1)'(1);
    col_hit   = (col_stop == frame_inc);
    is_last   = ({1'b0, current_column} + wmmd_pkg::COLS_W'(1)) >= cols_eff;
    can_emit  = emit_cnt < wmmd_pkg::EMIT_W'(wmmd_pkg::MAX_RESULTS);
    out_free  = !out_valid || !out_stall;
    step_ok   = !can_emit || out_free;
    // a closing column within the per-frame limit fills the output register
    out_load  = !cfg_hit && (state == wmmd_pkg::ST_COLUMN) && col_hit &&
                step_ok && can_emit;
    res_sum   = wmmd_pkg::COLS_W'(boundary_residue) + wmmd_pkg::COLS_W'(step_r);
    res_wrap  = (res_sum >= cols_eff);
    res_next  = res_wrap ? (res_sum - cols_eff) : res_sum;
    end_adv   = column_end_frame + step_q + wmmd_pkg::LEN_W'(res_wrap);
    // the next column already owns the current frame
    refold    = (column_end_frame <= frame_position);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wmmd_pkg::ST_CFG_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    if (cfg_hit) begin
      state_next = wmmd_pkg::ST_CFG_LOAD;
    end else begin
      unique case (state)
        wmmd_pkg::ST_CFG_LOAD:  state_next = wmmd_pkg::ST_CFG_DIV;
        wmmd_pkg::ST_CFG_DIV:   if (div_rsp.done) state_next = wmmd_pkg::ST_IDLE;
        wmmd_pkg::ST_IDLE:      if (in_acc && frame_close) state_next = wmmd_pkg::ST_MEAN_LOAD;
        wmmd_pkg::ST_MEAN_LOAD: state_next = wmmd_pkg::ST_MEAN_DIV;
        wmmd_pkg::ST_MEAN_DIV:  if (div_rsp.done) state_next = wmmd_pkg::ST_COLUMN;
        wmmd_pkg::ST_COLUMN: begin
          if (!col_hit)
            state_next = wmmd_pkg::ST_IDLE;
          else if (step_ok && is_last)
            state_next = wmmd_pkg::ST_IDLE;
        end
        default:                state_next = wmmd_pkg::ST_CFG_LOAD;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      chan_cfg         <= wmmd_pkg::CHAN_RESET;
      cols_cfg         <= wmmd_pkg::COLS_RESET;
      len_cfg          <= wmmd_pkg::LEN_RESET;
      frame_sum        <= '0;
      channel_position <= '0;
      frame_position   <= '0;
      current_column   <= '0;
      column_start     <= '0;
      running_min      <= wmmd_pkg::SAMPLE_MAX;
      running_max      <= wmmd_pkg::SAMPLE_MIN;
      emit_cnt         <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (out_load)
        out_valid <= 1'b1;
      else if (out_valid && !out_stall)
        out_valid <= 1'b0;

      if (cfg_hit) begin
        unique case (cfg_index)
          wmmd_pkg::REG_CHANNEL_COUNT:  chan_cfg <= cfg_data[wmmd_pkg::CHAN_W-1:0];
          wmmd_pkg::REG_COLUMN_COUNT:   cols_cfg <= cfg_data[wmmd_pkg::COLS_W-1:0];
          default:                      len_cfg  <= cfg_data[wmmd_pkg::LEN_W-1:0];
        endcase
        // drop partial frame and columns; boundaries reload after the divide
        frame_sum        <= '0;
        channel_position <= '0;
        frame_position   <= '0;
        current_column   <= '0;
        column_start     <= '0;
        running_min      <= wmmd_pkg::SAMPLE_MAX;
        running_max      <= wmmd_pkg::SAMPLE_MIN;
      end else begin
        unique case (state)
          wmmd_pkg::ST_CFG_DIV: begin
            if (div_rsp.done) begin
              step_q           <= div_rsp.quotient;
              step_r           <= div_rsp.remainder[wmmd_pkg::COL_IDX_W-1:0];
              column_end_frame <= div_rsp.quotient;
              boundary_residue <= div_rsp.remainder[wmmd_pkg::COL_IDX_W-1:0];
            end
          end
          wmmd_pkg::ST_IDLE: begin
            if (in_acc) begin
              frame_sum        <= sum_next;
              channel_position <= frame_close ? channel_position
                                              : cpos_inc[wmmd_pkg::CPOS_W-1:0];
            end
          end
          wmmd_pkg::ST_MEAN_DIV: begin
            if (div_rsp.done) begin
              mono             <= mean_val;
              if (mean_val < running_min) running_min <= mean_val;
              if (mean_val > running_max) running_max <= mean_val;
              frame_sum        <= '0;
              channel_position <= '0;
              emit_cnt         <= '0;
            end
          end
          wmmd_pkg::ST_COLUMN: begin
            if (!col_hit) begin
              frame_position <= frame_inc[wmmd_pkg::LEN_W-1:0];
            end else if (step_ok) begin
              if (can_emit) begin
                column_min   <= running_min;
                column_max   <= running_max;
                column_index <= current_column;
                last_column  <= is_last;
                emit_cnt     <= emit_cnt + wmmd_pkg::EMIT_W'(1);
              end
              if (is_last) begin
                // segment done: restart with the stored N / W split
                frame_position   <= '0;
                current_column   <= '0;
                column_start     <= '0;
                column_end_frame <= step_q;
                boundary_residue <= step_r;
                running_min      <= wmmd_pkg::SAMPLE_MAX;
                running_max      <= wmmd_pkg::SAMPLE_MIN;
              end else begin
                current_column   <= current_column + wmmd_pkg::COL_IDX_W'(1);
                column_start     <= column_end_frame;
                column_end_frame <= end_adv;
                boundary_residue <= res_next[wmmd_pkg::COL_IDX_W-1:0];
                running_min      <= refold ? mono : wmmd_pkg::SAMPLE_MAX;
                running_max      <= refold ? mono : wmmd_pkg::SAMPLE_MIN;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/wmmd_checker.sv -----
// ----------------------------------------------------------------------------
// wmmd_checker
// Port-level checks for the waveform min/max decimator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module wmmd_checker (
  input wire                                     clk,
  input wire                                     rst,
  input wire                                     cfg_write,
  input wire [wmmd_pkg::CFG_IDX_W-1:0]           cfg_index,
  input wire                                     in_stall,
  input wire                                     out_valid,
  input wire                                     out_stall,
  input wire signed [wmmd_pkg::SAMPLE_BITS-1:0]  column_min,
  input wire signed [wmmd_pkg::SAMPLE_BITS-1:0]  column_max,
  input wire [wmmd_pkg::COL_IDX_W-1:0]           column_index,
  input wire                                     last_column
);

  localparam logic [wmmd_pkg::COL_IDX_W-1:0] LAST_MIN =
    wmmd_pkg::COL_IDX_W'(wmmd_pkg::MIN_COLUMNS - 1);

  logic [2*wmmd_pkg::SAMPLE_BITS+wmmd_pkg::COL_IDX_W:0] out_word;
  logic                                                 cfg_listed;

  assign out_word   = {column_min, column_max, column_index, last_column};
  assign cfg_listed = (cfg_index == wmmd_pkg::REG_CHANNEL_COUNT) ||
                      (cfg_index == wmmd_pkg::REG_COLUMN_COUNT) ||
                      (cfg_index == wmmd_pkg::REG_SEGMENT_LENGTH);

  // stalled result holds
  `WMMD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_word))
  // every reported column saw at least one mono value
  `WMMD_ASSERT(a_min_le_max, out_valid |-> column_min <= column_max)
  // a segment has at least the minimum column count
  `WMMD_ASSERT(a_last_index, out_valid && last_column |-> column_index >= LAST_MIN)
  // a listed register write starts the boundary divide
  `WMMD_ASSERT(a_cfg_busy, cfg_write && cfg_listed |=> in_stall)
  // the boundary divide also runs out of reset
  `WMMD_ASSERT_NR(a_rst_busy, rst |=> in_stall)

endmodule

bind waveform_min_max_decimator wmmd_checker u_wmmd_checker (
  .clk          (clk),
  .rst          (rst),
  .cfg_write    (cfg_write),
  .cfg_index    (cfg_index),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .column_min   (column_min),
  .column_max   (column_max),
  .column_index (column_index),
  .last_column  (last_column)
);

`default_nettype wire
